@@ hw/rtl/bkc_pkg.sv @@
// shared types, codes and constants for the b-tree key comparator
package bkc_pkg;

    localparam int MAX_KEY_BYTES_DEF = 256;

    localparam logic [7:0] TOP_BIT  = 8'h80;
    localparam logic [7:0] LOW_MASK = 8'h7f;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_NODE   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    localparam logic [1:0] SK_INDEX   = 2'd0;
    localparam logic [1:0] SK_LONG    = 2'd1;
    localparam logic [1:0] SK_SEGMENT = 2'd2;
    localparam logic [1:0] SK_OTHER   = 2'd3;

    localparam logic [1:0] NK_BRANCH = 2'd0;
    localparam logic [1:0] NK_LEAF   = 2'd1;
    localparam logic [1:0] NK_OTHER  = 2'd2;

    localparam logic [1:0] VERD_LT = 2'd0;
    localparam logic [1:0] VERD_LE = 2'd1;
    localparam logic [1:0] VERD_EQ = 2'd2;
    localparam logic [1:0] VERD_GT = 2'd3;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_BAD_SEARCH = 3'd1;
    localparam logic [2:0] STAT_BAD_NODE   = 3'd2;
    localparam logic [2:0] STAT_NO_KEY     = 3'd3;
    localparam logic [2:0] STAT_TOO_LONG   = 3'd4;

    typedef enum logic [1:0] {
        ORD_EQ = 2'd0,
        ORD_LT = 2'd1,
        ORD_GT = 2'd2
    } order_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } eng_state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_byte;
        logic [1:0] key_kind;
        logic       begins_key;
        logic       ends_key;
    } item_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] status;
    } result_t;

endpackage

@@ hw/rtl/bkc_key_mem.sv @@
// search key byte store, one write and one registered read port
module bkc_key_mem
    import bkc_pkg::*;
#(
    parameter int DEPTH = MAX_KEY_BYTES_DEF,
    parameter int AW    = $clog2(MAX_KEY_BYTES_DEF)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/bkc_engine.sv @@
// key load control, node byte compare and verdict logic
module bkc_engine
    import bkc_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
    parameter int AW            = $clog2(MAX_KEY_BYTES),
    parameter int LW            = $clog2(MAX_KEY_BYTES + 2)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  item_t         item,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res_data,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output logic [7:0]    mem_wr_data,
    output logic          mem_rd_en,
    output logic [AW-1:0] mem_rd_addr,
    input  logic [7:0]    mem_rd_data
);

    localparam logic [LW-1:0] MAX_L  = LW'(MAX_KEY_BYTES);
    localparam logic [LW-1:0] OVER_L = LW'(MAX_KEY_BYTES + 1);
    localparam logic [LW-1:0] ONE_L  = LW'(1);

    eng_state_t    state_reg, state_next;
    item_t         item_reg;
    logic [LW-1:0] slen_reg, slen_next;
    logic [1:0]    skind_reg, skind_next;
    logic          loaded_reg, loaded_next;
    logic [1:0]    nkind_reg, nkind_next;
    logic [LW-1:0] pos_reg, pos_next;
    order_t        order_reg, order_next;
    logic          sticky_reg, sticky_next;

    logic          accept;
    logic [LW-1:0] len_in;
    logic [LW-1:0] pos_in;
    logic [LW-1:0] idx_in;

    logic [LW-1:0] pos0, pos1;
    order_t        ord0, ord1, ord_v;
    logic          sticky0, sticky1;
    logic [1:0]    nk;
    logic          do_cmp;
    logic [7:0]    sb;
    logic [7:0]    nb;
    logic          emit;
    logic          fire;
    logic [1:0]    verdict;
    logic [2:0]    status;

    assign accept = item_valid && (state_reg == ST_IDLE);

    // load path and read address, taken from the incoming transfer
    assign len_in = item.begins_key ? '0 : slen_reg;
    assign pos_in = item.begins_key ? '0 : pos_reg;
    assign idx_in = (skind_reg == SK_LONG) ? (slen_reg - ONE_L - pos_in) : pos_in;

    assign mem_wr_en   = accept && (item.action == ACT_LOAD) && (len_in < MAX_L);
    assign mem_wr_addr = len_in[AW-1:0];
    assign mem_wr_data = item.key_byte;
    assign mem_rd_en   = accept && (item.action == ACT_NODE);
    assign mem_rd_addr = idx_in[AW-1:0];

    // node byte step on the held transfer
    always_comb
    begin
        pos0    = item_reg.begins_key ? '0 : pos_reg;
        ord0    = item_reg.begins_key ? ORD_EQ : order_reg;
        sticky0 = item_reg.begins_key ? 1'b0 : sticky_reg;
        nk      = item_reg.begins_key ? item_reg.key_kind : nkind_reg;
        nb      = item_reg.key_byte;
        pos1    = pos0;
        ord1    = ord0;
        sticky1 = sticky0;
        do_cmp  = 1'b0;
        sb      = mem_rd_data;
        if (item_reg.action == ACT_NODE)
        begin
            if (pos0 >= MAX_L)
            begin
                pos1    = OVER_L;
                sticky1 = 1'b1;
            end
            else
            begin
                do_cmp = (ord0 == ORD_EQ) && loaded_reg && (skind_reg != SK_OTHER) &&
                         (nk <= NK_LEAF) && (slen_reg <= MAX_L) && (pos0 < slen_reg);
                if ((skind_reg == SK_INDEX) && (nk == NK_LEAF) && (pos0 == ONE_L) &&
                    ((mem_rd_data & TOP_BIT) != 8'h00) &&
                    ((mem_rd_data & LOW_MASK) == nb))
                begin
                    sb = mem_rd_data & LOW_MASK;
                end
                if (do_cmp)
                begin
                    if (sb > nb)
                    begin
                        ord1 = ORD_GT;
                    end
                    else if (sb < nb)
                    begin
                        ord1 = ORD_LT;
                    end
                end
                pos1 = pos0 + ONE_L;
            end
        end
    end

    assign emit = (item_reg.action == ACT_FINISH) ||
                  ((item_reg.action == ACT_NODE) && item_reg.ends_key);
    assign fire = !emit || res_ready;

    // verdict and status
    always_comb
    begin
        verdict = VERD_LT;
        status  = STAT_OK;
        ord_v   = (pos1 == '0) ? ORD_LT : ord1;
        if (!loaded_reg || (slen_reg == '0))
        begin
            status = STAT_NO_KEY;
        end
        else if (skind_reg == SK_OTHER)
        begin
            status = STAT_BAD_SEARCH;
        end
        else if (nk > NK_LEAF)
        begin
            status = STAT_BAD_NODE;
        end
        else if ((slen_reg > MAX_L) || sticky1 || (pos1 > MAX_L))
        begin
            status = STAT_TOO_LONG;
        end
        if (status == STAT_OK)
        begin
            if (ord_v == ORD_GT)
            begin
                verdict = VERD_GT;
            end
            else if (nk == NK_BRANCH)
            begin
                if (skind_reg == SK_INDEX)
                begin
                    verdict = (ord_v == ORD_EQ) ? VERD_GT : VERD_EQ;
                end
                else
                begin
                    verdict = ((ord_v == ORD_EQ) && (slen_reg > pos1)) ? VERD_GT : VERD_LE;
                end
            end
            else
            begin
                if ((ord_v == ORD_LT) || (slen_reg < pos1))
                begin
                    verdict = VERD_LT;
                end
                else if (slen_reg > pos1)
                begin
                    verdict = VERD_GT;
                end
                else
                begin
                    verdict = VERD_EQ;
                end
            end
        end
    end

    assign res_data.verdict = verdict;
    assign res_data.status  = status;

    // state register updates
    always_comb
    begin
        slen_next   = slen_reg;
        skind_next  = skind_reg;
        loaded_next = loaded_reg;
        nkind_next  = nkind_reg;
        pos_next    = pos_reg;
        order_next  = order_reg;
        sticky_next = sticky_reg;
        if (accept && (item.action == ACT_LOAD))
        begin
            if (item.begins_key)
            begin
                skind_next = item.key_kind;
            end
            slen_next   = (len_in <= MAX_L) ? (len_in + ONE_L) : len_in;
            loaded_next = 1'b1;
            pos_next    = '0;
            order_next  = ORD_EQ;
            sticky_next = 1'b0;
        end
        else if ((state_reg == ST_EXEC) && fire)
        begin
            nkind_next = nk;
            if (emit)
            begin
                pos_next    = '0;
                order_next  = ORD_EQ;
                sticky_next = 1'b0;
            end
            else
            begin
                pos_next    = pos1;
                order_next  = ord1;
                sticky_next = sticky1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && (item.action inside {ACT_NODE, ACT_FINISH}))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        res_valid  = (state_reg == ST_EXEC) && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            slen_reg   <= '0;
            skind_reg  <= SK_INDEX;
            loaded_reg <= 1'b0;
            nkind_reg  <= NK_BRANCH;
            pos_reg    <= '0;
            order_reg  <= ORD_EQ;
            sticky_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slen_reg   <= slen_next;
            skind_reg  <= skind_next;
            loaded_reg <= loaded_next;
            nkind_reg  <= nkind_next;
            pos_reg    <= pos_next;
            order_reg  <= order_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    a_no_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> (!mem_wr_en && !mem_rd_en))
        else $error("store accessed while a node byte is in flight");

    a_result_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (state_reg == ST_EXEC))
        else $error("result offered outside exec");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (slen_reg <= OVER_L) && (pos_reg <= OVER_L))
        else $error("length counter past its limit");

    a_restart_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && emit && res_ready) |=>
        ((pos_reg == '0) && (order_reg == ORD_EQ) && !sticky_reg))
        else $error("node state not restarted after verdict");

endmodule

@@ hw/rtl/btree_key_compare_top.sv @@
// top level of the b-tree search key comparator
//
// item channel: one transfer per byte. action load writes a search key byte
// into the key store (begins_key restarts the key and takes its kind); a
// node byte is compared against the stored key; finish closes a node key.
// load transfers are taken one per cycle. a node byte reads the key store
// (single registered read port) when taken, then a compare step updates
// the running order; finish has only the compare step. the item side stalls
// until the compare step ends. result channel: one verdict/status transfer
// per finished node key, held in an output register and valid once the
// closing transfer has left the compare step. if the receiver stalls, a new
// item is still taken; only a second verdict waits in the compare step
// until the register frees. reset clears all key lengths, kinds, order and
// status state; key store contents are not cleared, and a byte is used in
// the compare only once written. no clearing pass is needed after reset.
module btree_key_compare_top
    import bkc_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int AW = $clog2(MAX_KEY_BYTES);
    localparam int LW = $clog2(MAX_KEY_BYTES + 2);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    logic          eng_valid;
    logic          push_ok;
    result_t       eng_data;

    logic          result_valid_reg, result_valid_next;
    result_t       result_reg;

    bkc_key_mem #(
        .DEPTH (MAX_KEY_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bkc_engine #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .AW            (AW),
        .LW            (LW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .res_valid   (eng_valid),
        .res_ready   (push_ok),
        .res_data    (eng_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // output register
    assign push_ok = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (eng_valid && push_ok)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && push_ok)
        begin
            result_reg <= eng_data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
